// ----- src/csu_pkg.sv -----
// ----------------------------------------------------------------------------
// csu_pkg
// Shared types, codes and defaults of the counting semaphore unit.
// ----------------------------------------------------------------------------
package csu_pkg;

  localparam int NUM_SEMS_DEF   = 16;
  localparam int WAIT_DEPTH_DEF = 16;
  localparam int COUNT_MAX_DEF  = 255;

  localparam int CMD_W     = 2;
  localparam int SEM_IDX_W = 4;
  localparam int PID_W     = 4;
  localparam int S_DATA_W  = 8;
  localparam int M_DATA_W  = 16;

  typedef enum logic [CMD_W-1:0] {
    CMD_REQUEST = 2'd0,
    CMD_WAIT    = 2'd1,
    CMD_POST    = 2'd2
  } cmd_e;

  // controller to datapath
  typedef struct packed {
    logic accept;    // capture item, read semaphore table
    logic exec;      // commit table update and load result
    logic wake_rd;   // commit dequeue, read wait store
    logic wake_out;  // load woken pid as result
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic wake;      // post that releases a waiter
    logic out_busy;  // result register full and stalled
  } stat_t;

endpackage

// ----- src/csu_ctrl.sv -----
// ----------------------------------------------------------------------------
// csu_ctrl
// Sequencer of the semaphore unit: accept, execute, optional wait-store read.
// ----------------------------------------------------------------------------
module csu_ctrl import csu_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_WAKE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d       = state_q;
    ctrl_o        = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          ctrl_o.accept = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat_i.wake) begin
          ctrl_o.wake_rd = 1'b1;
          state_d        = ST_WAKE;
        end else if (!stat_i.out_busy) begin
          ctrl_o.exec = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      ST_WAKE: begin
        if (!stat_i.out_busy) begin
          ctrl_o.wake_out = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/csu_datapath.sv -----
// ----------------------------------------------------------------------------
// csu_datapath
// Free-list counter, semaphore table, wait store and result register.
// ----------------------------------------------------------------------------
module csu_datapath import csu_pkg::*; #(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int COUNT_MAX  = COUNT_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  output stat_t                stat_o,
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  input  logic [CMD_W-1:0]     s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_DATA_W-1:0]  m_axis_tdata
);

  localparam int SEM_W    = $clog2(NUM_SEMS);
  localparam int FCNT_W   = $clog2(NUM_SEMS + 1);
  localparam int CNT_W    = $clog2(COUNT_MAX + 1);
  localparam int HEAD_W   = $clog2(WAIT_DEPTH);
  localparam int SIZE_W   = $clog2(WAIT_DEPTH + 1);
  localparam int SUM_W    = SIZE_W + 1;
  localparam int ST_DEPTH = NUM_SEMS * WAIT_DEPTH;
  localparam int ST_AW    = $clog2(ST_DEPTH);

  // semaphore table and wait store
  logic [CNT_W-1:0]  cnt_mem [NUM_SEMS];
  logic [HEAD_W-1:0] hd_mem  [NUM_SEMS];
  logic [SIZE_W-1:0] sz_mem  [NUM_SEMS];
  logic [PID_W-1:0]  st_mem  [ST_DEPTH];
  logic [NUM_SEMS-1:0] vld_q;

  cmd_e                 cmd_q;
  logic [SEM_IDX_W-1:0] sem_q;
  logic [PID_W-1:0]     pid_q;
  logic [CNT_W-1:0]     cnt_rd_q;
  logic [HEAD_W-1:0]    hd_rd_q;
  logic [SIZE_W-1:0]    sz_rd_q;
  logic                 vld_rd_q;
  logic [PID_W-1:0]     st_rd_q;
  logic [SEM_W-1:0]     free_head_q;
  logic [FCNT_W-1:0]    free_cnt_q;

  logic                 out_valid_q;
  logic                 grant_valid_q, caller_blocked_q, woken_valid_q, fault_q;
  logic [SEM_IDX_W-1:0] granted_sem_q;
  logic [PID_W-1:0]     woken_pid_q;

  logic [SEM_W-1:0]     rd_idx;
  logic [SEM_W-1:0]     sem_idx;
  logic                 sem_ok;
  logic                 has_free;
  logic [CNT_W-1:0]     cnt;
  logic [HEAD_W-1:0]    hd;
  logic [SIZE_W-1:0]    sz;
  logic [CNT_W-1:0]     cnt_d;
  logic [HEAD_W-1:0]    hd_d;
  logic [SIZE_W-1:0]    sz_d;
  logic                 tab_we;
  logic                 st_we;
  logic                 do_grant;
  logic                 res_blocked;
  logic                 res_fault;
  logic [SUM_W-1:0]     slot_sum;
  logic [SUM_W-1:0]     slot_wrap;
  logic [HEAD_W-1:0]    slot;
  logic [ST_AW-1:0]     st_base;
  logic [ST_AW-1:0]     st_wr_addr;
  logic [ST_AW-1:0]     st_rd_addr;

  assign rd_idx   = SEM_W'(s_axis_tdata[SEM_IDX_W-1:0]);
  assign sem_idx  = SEM_W'(sem_q);
  assign sem_ok   = int'(sem_q) < NUM_SEMS;
  assign has_free = free_cnt_q != '0;

  assign cnt = vld_rd_q ? cnt_rd_q : '0;
  assign hd  = vld_rd_q ? hd_rd_q  : '0;
  assign sz  = vld_rd_q ? sz_rd_q  : '0;

  assign slot_sum   = SUM_W'(hd) + SUM_W'(sz);
  assign slot_wrap  = (slot_sum >= SUM_W'(WAIT_DEPTH)) ? slot_sum - SUM_W'(WAIT_DEPTH)
                                                       : slot_sum;
  assign slot       = slot_wrap[HEAD_W-1:0];
  assign st_base    = ST_AW'(sem_idx) * ST_AW'(WAIT_DEPTH);
  assign st_wr_addr = st_base + ST_AW'(slot);
  assign st_rd_addr = st_base + ST_AW'(hd);

  always_comb begin
    cnt_d           = cnt;
    hd_d            = hd;
    sz_d            = sz;
    tab_we          = 1'b0;
    st_we           = 1'b0;
    do_grant        = 1'b0;
    res_blocked     = 1'b0;
    res_fault       = 1'b0;
    stat_o.wake     = 1'b0;
    stat_o.out_busy = out_valid_q && !m_axis_tready;
    case (cmd_q)
      CMD_REQUEST: begin
        do_grant = has_free;
      end
      CMD_WAIT: begin
        if (sem_ok) begin
          tab_we = 1'b1;
          if (cnt != '0) begin
            cnt_d = cnt - CNT_W'(1);
          end else if (sz < SIZE_W'(WAIT_DEPTH)) begin
            sz_d        = sz + SIZE_W'(1);
            st_we       = 1'b1;
            res_blocked = 1'b1;
          end else begin
            res_fault = 1'b1;
          end
        end
      end
      CMD_POST: begin
        if (sem_ok) begin
          tab_we = 1'b1;
          if (sz == '0) begin
            if (cnt < CNT_W'(COUNT_MAX)) begin
              cnt_d = cnt + CNT_W'(1);
            end else begin
              res_fault = 1'b1;
            end
          end else begin
            stat_o.wake = 1'b1;
            sz_d        = sz - SIZE_W'(1);
            hd_d        = (hd == HEAD_W'(WAIT_DEPTH - 1)) ? '0 : hd + HEAD_W'(1);
          end
        end
      end
      default: begin
        tab_we = 1'b0;
      end
    endcase
  end

  // capture item and read table
  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      cmd_q    <= cmd_e'(s_axis_tuser);
      sem_q    <= s_axis_tdata[SEM_IDX_W-1:0];
      pid_q    <= s_axis_tdata[SEM_IDX_W +: PID_W];
      cnt_rd_q <= cnt_mem[rd_idx];
      hd_rd_q  <= hd_mem[rd_idx];
      sz_rd_q  <= sz_mem[rd_idx];
      vld_rd_q <= vld_q[rd_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.exec || ctrl_i.wake_rd) && tab_we) begin
      cnt_mem[sem_idx] <= cnt_d;
      hd_mem[sem_idx]  <= hd_d;
      sz_mem[sem_idx]  <= sz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec && st_we) begin
      st_mem[st_wr_addr] <= pid_q;
    end
    if (ctrl_i.wake_rd) begin
      st_rd_q <= st_mem[st_rd_addr];
    end
  end

  // valid bits and free list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      free_head_q <= '0;
      free_cnt_q  <= FCNT_W'(NUM_SEMS);
    end else if (ctrl_i.exec || ctrl_i.wake_rd) begin
      if (tab_we) begin
        vld_q[sem_idx] <= 1'b1;
      end
      if (do_grant) begin
        vld_q[free_head_q] <= 1'b0;
        free_head_q <= (free_head_q == SEM_W'(NUM_SEMS - 1)) ? '0
                                                             : free_head_q + SEM_W'(1);
        free_cnt_q  <= free_cnt_q - FCNT_W'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.exec || ctrl_i.wake_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec) begin
      grant_valid_q    <= do_grant;
      granted_sem_q    <= do_grant ? SEM_IDX_W'(free_head_q) : '0;
      caller_blocked_q <= res_blocked;
      woken_valid_q    <= 1'b0;
      woken_pid_q      <= '0;
      fault_q          <= res_fault;
    end else if (ctrl_i.wake_out) begin
      grant_valid_q    <= 1'b0;
      granted_sem_q    <= '0;
      caller_blocked_q <= 1'b0;
      woken_valid_q    <= 1'b1;
      woken_pid_q      <= st_rd_q;
      fault_q          <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, fault_q, woken_pid_q, woken_valid_q, caller_blocked_q,
                          granted_sem_q, grant_valid_q};

endmodule

// ----- src/counting_semaphore_unit.sv -----
// ----------------------------------------------------------------------------
// counting_semaphore_unit
// Pool of counting semaphores with per-semaphore FIFO wait queues.
// ----------------------------------------------------------------------------
// Each accepted item is a request, wait or post and yields one result item.
// It reads the semaphore table memory, then updates it and loads the result
// register. A post that releases a waiter reads the wait store with the
// update, then loads the result. One item is in work at a time; the next is
// accepted in the cycle after the result is loaded, while the result
// register may still hold it. No clearing pass is needed after reset.
module counting_semaphore_unit import csu_pkg::*; #(
  parameter int NUM_SEMS   = NUM_SEMS_DEF,
  parameter int WAIT_DEPTH = WAIT_DEPTH_DEF,
  parameter int COUNT_MAX  = COUNT_MAX_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [S_DATA_W-1:0] s_axis_tdata,   // sem_index[3:0], caller_pid[7:4]
  input  logic [CMD_W-1:0]    s_axis_tuser,   // cmd[1:0]
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [M_DATA_W-1:0] m_axis_tdata    // grant_valid[0], granted_sem[4:1],
                                              // caller_blocked[5], woken_valid[6],
                                              // woken_pid[10:7], fault[11]
);

  ctrl_t ctrl;
  stat_t stat;

  csu_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat_i        (stat),
    .ctrl_o        (ctrl)
  );

  csu_datapath #(
    .NUM_SEMS   (NUM_SEMS),
    .WAIT_DEPTH (WAIT_DEPTH),
    .COUNT_MAX  (COUNT_MAX)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .stat_o        (stat),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  a_one_in_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("item accepted while another is in work");

  a_ctrl_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl.accept, ctrl.exec, ctrl.wake_rd, ctrl.wake_out}))
    else $error("overlapping controller commands");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.exec || ctrl.wake_out) |-> !(m_axis_tvalid && !m_axis_tready))
    else $error("result loaded over a stalled result");

  a_wake_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.wake_out |=> (m_axis_tvalid && m_axis_tdata[6]))
    else $error("wake did not produce a woken result");

endmodule

// ----- tb/semaphore_pool_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// semaphore_pool_checker
// Watches both stream channels of the semaphore unit, predicts each result
// item from a private copy of the pool state and compares it field by field.
// ----------------------------------------------------------------------------
module semaphore_pool_checker import csu_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  input  logic                s_axis_tready_i,
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,   // sem_index[3:0], caller_pid[7:4]
  input  logic [CMD_W-1:0]    s_axis_tuser_i,   // cmd[1:0]
  input  logic                m_axis_tvalid_i,
  input  logic                m_axis_tready_i,
  input  logic [M_DATA_W-1:0] m_axis_tdata_i,   // grant_valid[0], granted_sem[4:1],
                                                // caller_blocked[5], woken_valid[6],
                                                // woken_pid[10:7], fault[11]
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic                 fault;
    logic [PID_W-1:0]     woken_pid;
    logic                 woken_valid;
    logic                 caller_blocked;
    logic [SEM_IDX_W-1:0] granted_sem;
    logic                 grant_valid;
  } outcome_t;

  localparam int OUTCOME_W = $bits(outcome_t);

  logic [SEM_IDX_W-1:0] free_ids [NUM_SEMS_DEF];
  int                   free_head;
  int                   free_left;
  int                   sem_count [NUM_SEMS_DEF];
  logic [PID_W-1:0]     waiters [NUM_SEMS_DEF][WAIT_DEPTH_DEF];
  int                   wq_head [NUM_SEMS_DEF];
  int                   wq_size [NUM_SEMS_DEF];
  outcome_t             expected_outcomes [$];
  outcome_t             got;
  outcome_t             want;

  function automatic outcome_t apply_semaphore_op(cmd_e op, logic [SEM_IDX_W-1:0] sem,
                                                  logic [PID_W-1:0] pid);
    outcome_t res;
    int       id;
    int       slot;
    res = '0;
    case (op)
      CMD_REQUEST: begin
        if (free_left > 0) begin
          id = free_ids[free_head];
          free_head = (free_head + 1) % NUM_SEMS_DEF;
          free_left--;
          sem_count[id] = 0;
          wq_head[id] = 0;
          wq_size[id] = 0;
          res.grant_valid = 1'b1;
          res.granted_sem = id[SEM_IDX_W-1:0];
        end
      end
      CMD_WAIT: begin
        if (sem_count[sem] > 0) begin
          sem_count[sem]--;
        end else if (wq_size[sem] < WAIT_DEPTH_DEF) begin
          slot = (wq_head[sem] + wq_size[sem]) % WAIT_DEPTH_DEF;
          waiters[sem][slot] = pid;
          wq_size[sem]++;
          res.caller_blocked = 1'b1;
        end else begin
          res.fault = 1'b1;
        end
      end
      CMD_POST: begin
        if (wq_size[sem] == 0) begin
          if (sem_count[sem] < COUNT_MAX_DEF) begin
            sem_count[sem]++;
          end else begin
            res.fault = 1'b1;
          end
        end else begin
          res.woken_valid = 1'b1;
          res.woken_pid = waiters[sem][wq_head[sem]];
          wq_head[sem] = (wq_head[sem] + 1) % WAIT_DEPTH_DEF;
          wq_size[sem]--;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_SEMS_DEF; i++) begin
        free_ids[i] = i[SEM_IDX_W-1:0];
        sem_count[i] = 0;
        wq_head[i] = 0;
        wq_size[i] = 0;
      end
      free_head = 0;
      free_left = NUM_SEMS_DEF;
      expected_outcomes.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = m_axis_tdata_i[OUTCOME_W-1:0];
        if (expected_outcomes.size() == 0) begin
          $error("result item with no expected outcome pending");
          fail_count_o++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("grant_valid", int'(want.grant_valid), int'(got.grant_valid));
          check_field("granted_sem", int'(want.granted_sem), int'(got.granted_sem));
          check_field("caller_blocked", int'(want.caller_blocked),
                      int'(got.caller_blocked));
          check_field("woken_valid", int'(want.woken_valid), int'(got.woken_valid));
          check_field("woken_pid", int'(want.woken_pid), int'(got.woken_pid));
          check_field("fault", int'(want.fault), int'(got.fault));
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_outcomes.push_back(apply_semaphore_op(cmd_e'(s_axis_tuser_i),
                                                       s_axis_tdata_i[SEM_IDX_W-1:0],
                                                       s_axis_tdata_i[SEM_IDX_W +: PID_W]));
      end
      pending_o = expected_outcomes.size();
    end
  end

endmodule

// ----- tb/counting_semaphore_unit_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// counting_semaphore_unit_test
// Drives request, wait, post and unused-command items into the semaphore unit with random
// gaps and back-pressure; a checker beside the unit predicts every result.
// ----------------------------------------------------------------------------
module counting_semaphore_unit_test import csu_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int               NUM_ITEMS  = 1450;
  localparam int               STALL_PCT  = 29;
  localparam int               IDLE_LIMIT = 1000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;   // sem_index[3:0], caller_pid[7:4]
  logic [CMD_W-1:0]    s_axis_tuser = '0;   // cmd[1:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;        // grant_valid[0], granted_sem[4:1],
                                            // caller_blocked[5], woken_valid[6],
                                            // woken_pid[10:7], fault[11]
  logic                s_taken = 1'b0;
  logic                steady = 1'b0;
  int                  fail_count;
  int                  pending;
  int                  items_sent = 0;
  int                  idle_cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  counting_semaphore_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  semaphore_pool_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    s_taken <= s_axis_tvalid && s_axis_tready;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready <= steady || ($urandom_range(99) >= STALL_PCT);
  end

  task automatic send_item(logic [CMD_W-1:0] op, logic [SEM_IDX_W-1:0] sem,
                           logic [PID_W-1:0] pid);
    while (!steady && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {pid, sem};
    do @(negedge clk_i); while (!s_taken);
    items_sent++;
    steady <= (items_sent >= 700 && items_sent < 900);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  function automatic logic [CMD_W-1:0] noise_op();
    int k;
    k = $urandom_range(99);
    if (k < 8) return CMD_REQUEST;
    if (k < 10) return CMD_UNUSED;
    if (k < 55) return CMD_WAIT;
    return CMD_POST;
  endfunction

  initial begin
    logic [SEM_IDX_W-1:0] sem;
    int                   pick;
    int                   n;
    bit                   saturated;
    bit                   paused;
    saturated = 1'b0;
    paused = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_item(CMD_REQUEST, 4'd0, 4'd0);
    send_item(CMD_WAIT, 4'd0, 4'd15);
    send_item(CMD_WAIT, 4'd0, 4'd0);
    send_item(CMD_POST, 4'd0, 4'd3);
    send_item(CMD_POST, 4'd0, 4'd3);
    send_item(CMD_POST, 4'd0, 4'd7);
    send_item(CMD_WAIT, 4'd0, 4'd7);
    send_item(CMD_POST, 4'd15, 4'd15);
    send_item(CMD_WAIT, 4'd15, 4'd0);
    send_item(CMD_WAIT, 4'd15, 4'd9);
    send_item(CMD_UNUSED, 4'd15, 4'd15);
    send_item(CMD_UNUSED, 4'd0, 4'd0);
    send_item(CMD_REQUEST, 4'd15, 4'd15);
    send_item(CMD_POST, 4'd15, 4'd0);
    send_item(CMD_POST, 4'd15, 4'd0);
    send_item(CMD_WAIT, 4'd15, 4'd5);
    drain_results();

    while (items_sent < NUM_ITEMS) begin
      sem = SEM_IDX_W'($urandom_range(15));
      pick = $urandom_range(99);
      if (!saturated && items_sent >= 400) begin
        saturated = 1'b1;
        repeat (275) send_item(CMD_POST, sem, PID_W'($urandom_range(15)));
        repeat (20) send_item(CMD_WAIT, sem, PID_W'($urandom_range(15)));
      end else if (!paused && items_sent >= 1000) begin
        paused = 1'b1;
        drain_results();
      end else if (pick < 35) begin
        send_item(noise_op(), SEM_IDX_W'($urandom_range(15)), PID_W'($urandom_range(15)));
      end else if (pick < 75) begin
        n = $urandom_range(1, 18);
        repeat (n) send_item(CMD_WAIT, sem, PID_W'($urandom_range(15)));
        n = $urandom_range(1, 18);
        repeat (n) send_item(CMD_POST, sem, PID_W'($urandom_range(15)));
      end else if (pick < 95) begin
        n = $urandom_range(4, 12);
        repeat (n) begin
          send_item($urandom_range(1) ? CMD_WAIT : CMD_POST, sem,
                    PID_W'($urandom_range(15)));
        end
      end else begin
        send_item(CMD_REQUEST, SEM_IDX_W'($urandom_range(15)), PID_W'($urandom_range(15)));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
